FILE: rtl/hsc_pkg.sv
// Package: shared constants, types and state codes for the Hermite segment coefficient core.
package hsc_pkg;
  localparam int FracBits = 12;
  localparam int InW = 24;
  localparam int CoefW = 32;
  localparam int DiffW = InW + 1;
  localparam int SumW = 2 * DiffW + 2;
  localparam int RootW = SumW / 2;
  localparam int TW = 40;
  localparam int SqrtSteps = SumW / 2;
  localparam int StepW = $clog2(SqrtSteps + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_SQRT, ST_T0, ST_T1, ST_M0, ST_M1, ST_COEF, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_start;
    logic sq_step;
    logic t0_calc;
    logic t1_calc;
    logic m0_calc;
    logic m1_calc;
    logic coef_calc;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic sq_done;
  } stat_t;
endpackage

FILE: rtl/hermite_segment_coefficients_core.sv
// Top level: cubic Hermite segment coefficient core.
//  channel  dir  fields
//  s_axis   in   tdata: pos,dir,width,spread,tension; tuser: start_chain
//  m_axis   out  tdata: coef_0..coef_3; tuser: axis; tlast: last
// A point that starts a segment goes from accept to the next accept through a sum step,
// 26 square root steps and a done check, the tangent scale states ST_T0 and ST_T1, then 4
// results, each through two tangent multiplies, coefficients and output, plus output waits.
// A first point of a chain is only loaded; the block stays idle. rst is synchronous and clears
// the control. A stalled result holds the block; no new point is taken until all four leave.
module hermite_segment_coefficients_core #(
  parameter int FRAC_BITS = hsc_pkg::FracBits
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [215:0] s_axis_tdata,  // pos_x,pos_y,pos_z,dir_x,dir_y,dir_z,width,spread,tension
  input  logic s_axis_tuser,          // start_chain
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [127:0] m_axis_tdata,  // coef_0,coef_1,coef_2,coef_3
  output logic [1:0] m_axis_tuser,    // axis
  output logic m_axis_tlast           // last
);
  hsc_pkg::cmd_t cmd;
  hsc_pkg::stat_t stat;
  logic signed [31:0] c0, c1, c2, c3;

  hsc_ctrl u_ctrl (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .start_chain(s_axis_tuser),
    .m_axis_tvalid, .m_axis_tready, .stat, .cmd
  );

  hsc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .cmd, .stat,
    .pos_x(s_axis_tdata[23:0]), .pos_y(s_axis_tdata[47:24]), .pos_z(s_axis_tdata[71:48]),
    .dir_x(s_axis_tdata[95:72]), .dir_y(s_axis_tdata[119:96]),
    .dir_z(s_axis_tdata[143:120]), .width(s_axis_tdata[167:144]),
    .spread(s_axis_tdata[191:168]), .tension(s_axis_tdata[215:192]),
    .axis(m_axis_tuser), .coef_0(c0), .coef_1(c1), .coef_2(c2), .coef_3(c3),
    .last(m_axis_tlast)
  );

  assign m_axis_tdata = {c3, c2, c1, c0};
endmodule

FILE: rtl/hsc_ctrl.sv
// Controller: sequences one point through sum, square root, tangents and four results.
module hsc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic start_chain,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  hsc_pkg::stat_t stat,
  output hsc_pkg::cmd_t cmd
);
  hsc_pkg::state_t state, state_next;
  logic have_prev;
  logic [1:0] axis, axis_next;
  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsc_pkg::ST_IDLE;
      have_prev <= 1'b0;
      axis <= 2'd0;
    end else begin
      state <= state_next;
      axis <= axis_next;
      if (s_fire) have_prev <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    axis_next = axis;
    case (state)
      hsc_pkg::ST_IDLE: if (s_fire && have_prev && !start_chain) state_next = hsc_pkg::ST_SUM;
      hsc_pkg::ST_SUM: state_next = hsc_pkg::ST_SQRT;
      hsc_pkg::ST_SQRT: if (stat.sq_done) state_next = hsc_pkg::ST_T0;
      hsc_pkg::ST_T0: state_next = hsc_pkg::ST_T1;
      hsc_pkg::ST_T1: begin
        state_next = hsc_pkg::ST_M0;
        axis_next = 2'd0;
      end
      hsc_pkg::ST_M0: state_next = hsc_pkg::ST_M1;
      hsc_pkg::ST_M1: state_next = hsc_pkg::ST_COEF;
      hsc_pkg::ST_COEF: state_next = hsc_pkg::ST_OUT;
      hsc_pkg::ST_OUT: if (m_axis_tready) begin
        axis_next = axis + 2'd1;
        state_next = (axis == 2'd3) ? hsc_pkg::ST_IDLE : hsc_pkg::ST_M0;
      end
      default: state_next = hsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    s_axis_tready = (state == hsc_pkg::ST_IDLE);
    m_axis_tvalid = (state == hsc_pkg::ST_OUT);
    cmd.load = s_fire;
    case (state)
      hsc_pkg::ST_SUM: cmd.sq_start = 1'b1;
      hsc_pkg::ST_SQRT: cmd.sq_step = 1'b1;
      hsc_pkg::ST_T0: cmd.t0_calc = 1'b1;
      hsc_pkg::ST_T1: cmd.t1_calc = 1'b1;
      hsc_pkg::ST_M0: cmd.m0_calc = 1'b1;
      hsc_pkg::ST_M1: cmd.m1_calc = 1'b1;
      hsc_pkg::ST_COEF: cmd.coef_calc = 1'b1;
      default: ;
    endcase
  end

  a_out_only_in_segment: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("output while accepting");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(axis))
    else $error("result dropped");
  a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    (state == hsc_pkg::ST_T0) |-> $past(state == hsc_pkg::ST_SQRT))
    else $error("bad sequence");
endmodule

FILE: rtl/hsc_datapath.sv
// Datapath: point registers, distance square root, tangent multiplies, coefficients.
module hsc_datapath #(
  parameter int FRAC_BITS = hsc_pkg::FracBits
) (
  input  logic clk,
  input  hsc_pkg::cmd_t cmd,
  output hsc_pkg::stat_t stat,
  input  logic signed [23:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
  input  logic signed [23:0] width, spread, tension,
  output logic [1:0] axis,
  output logic signed [31:0] coef_0, coef_1, coef_2, coef_3,
  output logic last
);
  localparam int SW = hsc_pkg::SumW;
  localparam int RW = hsc_pkg::RootW;
  localparam int TW = hsc_pkg::TW;
  localparam int PW = TW + 24;

  logic signed [23:0] pp [3], pd [3], cp [3], cd [3];
  logic signed [23:0] pw, ps, pt, cw, cs, ct;
  logic signed [24:0] df [3];
  logic signed [49:0] sq [3];
  logic [SW-1:0] rem, bitv, rr;
  logic [RW-1:0] root;
  logic signed [TW-1:0] t0, t1;
  logic signed [PW-1:0] m0, m1;
  logic signed [PW+3:0] c0w, c1w, c2w, c3w;

  function automatic logic signed [TW-1:0] sat_t(input logic signed [TW+RW+24:0] v);
    logic signed [TW+RW+24:0] sh;
    sh = v >>> FRAC_BITS;
    if (sh > $signed({{(RW+25){1'b0}}, {1'b0, {(TW-1){1'b1}}}}))
      sat_t = {1'b0, {(TW-1){1'b1}}};
    else if (sh < $signed({{(RW+25){1'b1}}, {1'b1, {(TW-1){1'b0}}}}))
      sat_t = {1'b1, {(TW-1){1'b0}}};
    else sat_t = sh[TW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW+3:0] v);
    if (v > $signed({{(PW-28){1'b0}}, 32'h7fffffff})) sat32 = 32'sh7fffffff;
    else if (v < $signed({{(PW-28){1'b1}}, 32'h80000000})) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  logic [SW-1:0] trial;
  assign trial = rr + bitv;
  assign stat.sq_done = (bitv == '0);

  assign sq[0] = df[0] * df[0];
  assign sq[1] = df[1] * df[1];
  assign sq[2] = df[2] * df[2];

  always_comb begin
    if (cmd.axis == 2'd3) begin
      c0w = (PW+4)'(pw);
      c1w = (PW+4)'(ps);
      c2w = 3 * ((PW+4)'(cw) - (PW+4)'(pw)) - 2 * (PW+4)'(ps) - (PW+4)'(cs);
      c3w = -2 * ((PW+4)'(cw) - (PW+4)'(pw)) + (PW+4)'(ps) + (PW+4)'(cs);
    end else begin
      c0w = (PW+4)'(pp[cmd.axis]);
      c1w = (PW+4)'(m0);
      c2w = 3 * ((PW+4)'(cp[cmd.axis]) - (PW+4)'(pp[cmd.axis])) - 2 * (PW+4)'(m0)
            - (PW+4)'(m1);
      c3w = -2 * ((PW+4)'(cp[cmd.axis]) - (PW+4)'(pp[cmd.axis])) + (PW+4)'(m0)
            + (PW+4)'(m1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pp[0] <= cp[0]; pp[1] <= cp[1]; pp[2] <= cp[2];
      pd[0] <= cd[0]; pd[1] <= cd[1]; pd[2] <= cd[2];
      pw <= cw; ps <= cs; pt <= ct;
      cp[0] <= pos_x; cp[1] <= pos_y; cp[2] <= pos_z;
      cd[0] <= dir_x; cd[1] <= dir_y; cd[2] <= dir_z;
      cw <= width; cs <= spread; ct <= tension;
      df[1] <= 25'(signed'(pos_y)) - 25'(signed'(cp[1]));
      df[2] <= 25'(signed'(pos_z)) - 25'(signed'(cp[2]));
      df[0] <= 25'(signed'(pos_x)) - 25'(signed'(cp[0]));
    end
    if (cmd.sq_start) begin
      rem <= SW'($unsigned(sq[0])) + SW'($unsigned(sq[1])) + SW'($unsigned(sq[2]));
      bitv <= {2'b01, {(SW-2){1'b0}}};
      rr <= '0;
    end
    if (cmd.sq_step && bitv != '0) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        rr <= (rr >> 1) + bitv;
      end else rr <= rr >> 1;
      bitv <= bitv >> 2;
    end
    if (cmd.t0_calc) begin
      root <= rr[RW-1:0];
      t0 <= sat_t((TW+RW+25)'($signed(pt)) * $signed({1'b0, rr[RW-1:0]}));
    end
    if (cmd.t1_calc) t1 <= sat_t((TW+RW+25)'($signed(ct)) * $signed({1'b0, root}));
    if (cmd.m0_calc) m0 <= (PW'(t0) * PW'(pd[cmd.axis])) >>> FRAC_BITS;
    if (cmd.m1_calc) m1 <= (PW'(t1) * PW'(cd[cmd.axis])) >>> FRAC_BITS;
    if (cmd.coef_calc) begin
      axis <= cmd.axis;
      last <= (cmd.axis == 2'd3);
      coef_0 <= sat32(c0w); coef_1 <= sat32(c1w);
      coef_2 <= sat32(c2w); coef_3 <= sat32(c3w);
    end
  end
endmodule

FILE: bench/hsc_checker.sv
// Checker: watches both streams, predicts Hermite coefficients and compares them.
`timescale 1ns / 100ps
module hsc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [215:0] in_data,
  input  logic         in_start,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [127:0] out_data,
  input  logic [1:0]   out_axis,
  input  logic         out_last,
  output int           errors,
  output int           pending,
  output int           segments
);
  localparam int FB = hsc_pkg::FracBits;
  localparam logic [1:0] AXIS_WIDTH = 2'd3;

  typedef struct {
    logic [1:0]         axis;
    logic signed [31:0] c [4];
    logic               last;
  } coef_set_t;

  coef_set_t coef_q [$];

  logic               has_prev;
  logic signed [63:0] p_pos [3];
  logic signed [63:0] p_dir [3];
  logic signed [63:0] p_w, p_s, p_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat_tan(input logic signed [63:0] v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] fld(input logic [215:0] d, input int k);
    return 64'(signed'(d[k*24 +: 24]));
  endfunction

  function automatic void push_set(input logic [1:0] ax, input logic signed [63:0] c0,
                                   input logic signed [63:0] c1,
                                   input logic signed [63:0] c2,
                                   input logic signed [63:0] c3);
    coef_set_t e;
    e.axis = ax;
    e.c[0] = sat32(c0);
    e.c[1] = sat32(c1);
    e.c[2] = sat32(c2);
    e.c[3] = sat32(c3);
    e.last = (ax == AXIS_WIDTH);
    coef_q.push_back(e);
  endfunction

  task automatic predict_point(input logic [215:0] d, input logic start);
    logic signed [63:0] pos [3];
    logic signed [63:0] dir [3];
    logic signed [63:0] w, s, t, df, d_len, t0, t1, m0, m1;
    logic [63:0] sum;
    for (int i = 0; i < 3; i++) begin
      pos[i] = fld(d, i);
      dir[i] = fld(d, 3 + i);
    end
    w = fld(d, 6);
    s = fld(d, 7);
    t = fld(d, 8);
    if (has_prev && !start) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        df = pos[i] - p_pos[i];
        sum += df * df;
      end
      d_len = int_sqrt(sum);
      t0 = sat_tan((p_t * d_len) >>> FB);
      t1 = sat_tan((t * d_len) >>> FB);
      for (int i = 0; i < 3; i++) begin
        df = pos[i] - p_pos[i];
        m0 = (t0 * p_dir[i]) >>> FB;
        m1 = (t1 * dir[i]) >>> FB;
        push_set(2'(i), p_pos[i], m0, 3 * df - 2 * m0 - m1, -2 * df + m0 + m1);
      end
      df = w - p_w;
      push_set(AXIS_WIDTH, p_w, p_s, 3 * df - 2 * p_s - s, -2 * df + p_s + s);
      segments++;
    end
    for (int i = 0; i < 3; i++) begin
      p_pos[i] = pos[i];
      p_dir[i] = dir[i];
    end
    p_w = w;
    p_s = s;
    p_t = t;
    has_prev = 1;
  endtask

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    segments = 0;
    pending = 0;
    has_prev = 0;
    for (int i = 0; i < 3; i++) begin
      p_pos[i] = 0;
      p_dir[i] = 0;
    end
    p_w = 0;
    p_s = 0;
    p_t = 0;
  end

  always @(posedge clk) begin
    coef_set_t e;
    if (!rst) begin
      if (in_valid && in_ready) predict_point(in_data, in_start);
      if (out_valid && out_ready) begin
        if (coef_q.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          e = coef_q.pop_front();
          if (out_axis !== e.axis)
            report($sformatf("axis got %0d want %0d", out_axis, e.axis));
          if (out_last !== e.last)
            report($sformatf("last got %b want %b on axis %0d", out_last, e.last, e.axis));
          for (int j = 0; j < 4; j++)
            if (out_data[j*32 +: 32] !== e.c[j])
              report($sformatf("axis %0d coef_%0d got %0d want %0d", e.axis, j,
                               $signed(out_data[j*32 +: 32]), e.c[j]));
        end
      end
    end
    pending = coef_q.size();
  end
endmodule

FILE: bench/tb_hermite_segment_coefficients_core.sv
// Testbench top: drives control points with bursts and stalls and gives the verdict.
`timescale 1ns / 100ps
module tb_hermite_segment_coefficients_core;
  localparam int RANDOM_POINTS = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [23:0] QMAX = 24'sh7fffff;
  localparam logic signed [23:0] QMIN = 24'sh800000;
  localparam logic signed [23:0] ONE = 24'sh001000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [215:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int  errors, pending, segments;
  int  cycles = 0;
  int  points_sent = 0;
  bit  hold_off = 0;
  bit  sink_steady = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  hermite_segment_coefficients_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  hsc_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_start(s_axis_tuser),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_axis(m_axis_tuser), .out_last(m_axis_tlast),
    .errors(errors), .pending(pending), .segments(segments)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: own stall pattern, long hold-off on request
  always @(posedge clk) begin
    if (hold_off) m_axis_tready <= 0;
    else if (sink_steady) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  function automatic logic signed [23:0] rnd_q(input int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'(signed'(24'($urandom_range(0, 8191))) - 24'sd4096);
      2: return $urandom_range(0, 1) ? QMAX : QMIN;
      default: return 24'(signed'(24'($urandom_range(0, 131071))) - 24'sd65536);
    endcase
  endfunction

  task automatic send_point(input bit start, input logic signed [23:0] f [9]);
    logic [215:0] d;
    for (int k = 0; k < 9; k++) d[k*24 +: 24] = f[k];
    s_axis_tdata  <= d;
    s_axis_tuser  <= start;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    points_sent++;
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0;
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_point(input bit start);
    logic signed [23:0] f [9];
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      f[k] = (mode == 0) ? rnd_q($urandom_range(0, 2)) : rnd_q($urandom_range(1, 3));
    if (mode > 4) begin
      f[3] = 24'($urandom_range(0, 1) ? ONE : -ONE);
      f[4] = 24'($urandom_range(0, 2048));
      f[5] = 24'($urandom_range(0, 2048));
    end
    send_point(start, f);
  endtask

  initial begin
    logic signed [23:0] f [9];
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, chain starts, zero distance, odd directions, both tension signs
    for (int k = 0; k < 9; k++) f[k] = QMIN;
    send_point(0, f);
    for (int k = 0; k < 9; k++) f[k] = QMAX;
    send_point(0, f);
    send_point(0, f);
    for (int k = 0; k < 9; k++) f[k] = 0;
    send_point(1, f);
    send_point(0, f);
    f[0] = 3 * ONE; f[1] = 4 * ONE; f[3] = ONE; f[8] = ONE;
    send_point(0, f);
    f[8] = -ONE; f[4] = -ONE; f[0] = -f[0];
    send_point(0, f);
    f[3] = QMAX; f[4] = QMIN; f[5] = QMAX; f[8] = QMAX; f[6] = QMIN; f[7] = QMAX;
    send_point(0, f);
    f[0] = QMIN; f[1] = QMAX; f[2] = QMIN; f[8] = QMIN; f[6] = QMAX; f[7] = QMIN;
    send_point(0, f);
    send_point(1, f);
    f[0] = QMAX; f[1] = QMIN; f[2] = QMAX;
    send_point(0, f);
    for (int k = 0; k < 9; k++) f[k] = 24'(k + 1);
    send_point(0, f);
    send_point(0, f);

    // long receiver hold-off while points keep coming
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++) random_point(0);
    join

    for (int i = 0; i < RANDOM_POINTS; i++) begin
      sink_steady = (i >= 150 && i < 190);
      random_point($urandom_range(0, 15) == 0);
      if (!(i >= 100 && i < 140)) gap();
    end
    s_axis_tvalid <= 0;
    sink_steady = 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d points, checked %0d segments of four axis results",
             points_sent, segments);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: hermite_segment_coefficients_core.f
rtl/hsc_pkg.sv
rtl/hsc_ctrl.sv
rtl/hsc_datapath.sv
rtl/hermite_segment_coefficients_core.sv
bench/hsc_checker.sv
bench/tb_hermite_segment_coefficients_core.sv
